// ===== sv/fos_pkg.sv =====
// ----------------------------------------------------------------------------
// fos_pkg
// Shared types and constants of the Fenwick order-statistic core.
// ----------------------------------------------------------------------------
package fos_pkg;

  // Default sizing of the count tree.
  localparam int unsigned DEPTH_DEF       = 1024;
  localparam int unsigned LOG_DEPTH_DEF   = 10;
  localparam int unsigned COUNT_WIDTH_DEF = 20;

  // Fixed field widths of the beats.
  localparam int unsigned VALUE_W  = 10;
  localparam int unsigned RANK_W   = 20;
  localparam int unsigned TOTAL_W  = 20;
  localparam int unsigned DOMAIN_W = 11;

  // Register file.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [DOMAIN_W-1:0] DOMAIN_RESET = 11'd1024;

  typedef enum logic [0:0] {
    REG_DOMAIN_SIZE = 1'b0
  } reg_idx_t;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_DOMAIN = 2'd1,
    STAT_RANK   = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS,
    ST_QRY,
    ST_FIN
  } eng_state_t;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   kth_value;
    logic [TOTAL_W-1:0]   total_count;
  } result_t;

endpackage

// ===== sv/fos_tree_mem.sv =====
// ----------------------------------------------------------------------------
// fos_tree_mem
// Single-port-write, single-port-read synchronous RAM holding the tree.
// ----------------------------------------------------------------------------
module fos_tree_mem #(
  parameter int unsigned DEPTH = fos_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = fos_pkg::COUNT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] tree_mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= tree_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/fos_apb_regs.sv =====
// ----------------------------------------------------------------------------
// fos_apb_regs
// APB register file; holds the domain size register.
// ----------------------------------------------------------------------------
module fos_apb_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fos_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fos_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fos_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [fos_pkg::DOMAIN_W-1:0]    domain_size
);

  logic [fos_pkg::DOMAIN_W-1:0] domain_r;
  logic [fos_pkg::DOMAIN_W-1:0] domain_nxt;
  logic                         hit_domain;

  // Word index sits above the byte offset.
  assign hit_domain = (paddr[2] == fos_pkg::REG_DOMAIN_SIZE);
  assign pready     = 1'b1;

  always_comb begin
    domain_nxt = domain_r;
    if (psel && penable && pwrite && hit_domain) begin
      domain_nxt = pwdata[fos_pkg::DOMAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      domain_r <= fos_pkg::DOMAIN_RESET;
    end else begin
      domain_r <= domain_nxt;
    end
  end

  assign prdata      = hit_domain ? fos_pkg::CFG_DATA_W'(domain_r) : '0;
  assign domain_size = domain_r;

endmodule

// ===== sv/fos_engine.sv =====
// ----------------------------------------------------------------------------
// fos_engine
// Sequencer for insert, k-th smallest search and the post-reset clear.
// ----------------------------------------------------------------------------
module fos_engine #(
  parameter int unsigned DEPTH       = fos_pkg::DEPTH_DEF,
  parameter int unsigned LOG_DEPTH   = fos_pkg::LOG_DEPTH_DEF,
  parameter int unsigned COUNT_WIDTH = fos_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fos_pkg::DOMAIN_W-1:0]  domain_i,
  input  logic                          start_i,
  input  logic                          op_i,
  input  logic [fos_pkg::VALUE_W-1:0]   value_i,
  input  logic [fos_pkg::RANK_W-1:0]    rank_i,
  input  logic                          out_free_i,
  output logic                          idle_o,
  output logic                          done_o,
  output fos_pkg::result_t              result_o,
  output logic                          rd_en_o,
  output logic [$clog2(DEPTH)-1:0]      rd_addr_o,
  input  logic [COUNT_WIDTH-1:0]        rd_data_i,
  output logic                          wr_en_o,
  output logic [$clog2(DEPTH)-1:0]      wr_addr_o,
  output logic [COUNT_WIDTH-1:0]        wr_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned XW = (LOG_DEPTH + 2 > fos_pkg::DOMAIN_W + 1) ?
                               LOG_DEPTH + 2 : fos_pkg::DOMAIN_W + 1;
  localparam int unsigned KW = (CW > fos_pkg::RANK_W) ? CW : fos_pkg::RANK_W;
  localparam int unsigned BW = $clog2(LOG_DEPTH + 1);

  fos_pkg::eng_state_t state_r, state_nxt;

  logic [AW-1:0]               clr_r, clr_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [XW-1:0]               pos_r, pos_nxt;
  logic [KW-1:0]               below_r, below_nxt;
  logic [KW-1:0]               k_r, k_nxt;
  logic [BW-1:0]               bit_r, bit_nxt;
  logic                        last_r, last_nxt;
  logic                        pend_r, pend_nxt;
  logic [XW-1:0]               cand_r, cand_nxt;
  logic [XW-1:0]               ipos_r, ipos_nxt;
  logic                        wpend_r, wpend_nxt;
  logic [AW-1:0]               waddr_r, waddr_nxt;
  fos_pkg::status_t            status_r, status_nxt;
  logic [fos_pkg::VALUE_W-1:0] kth_r, kth_nxt;

  logic [XW-1:0] dom_eff;
  logic          ins_bad_dom;
  logic          ins_full;
  logic [KW-1:0] k_ext;
  logic          q_bad;
  logic [KW:0]   sum;
  logic          take;
  logic [XW-1:0] pos_now;
  logic [KW-1:0] below_now;
  logic [XW-1:0] cand;
  logic          cand_ok;
  logic          ipos_in;
  logic [XW-1:0] ipos_step;

  // Effective domain and per-step arithmetic of the insert and search walks.
  always_comb begin
    dom_eff     = (XW'(domain_i) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(domain_i);
    ins_bad_dom = (XW'(value_i) >= dom_eff);
    ins_full    = &cnt_r;
    k_ext       = KW'(rank_i);
    q_bad       = (k_ext == '0) || (k_ext > KW'(cnt_r));
    // The search only advances while the prefix stays below k.
    sum         = {1'b0, below_r} + (KW + 1)'(rd_data_i);
    take        = pend_r && (sum < {1'b0, k_r});
    pos_now     = take ? cand_r : pos_r;
    below_now   = take ? sum[KW-1:0] : below_r;
    cand        = pos_now | (XW'(1) << bit_r);
    cand_ok     = (cand <= dom_eff);
    ipos_in     = (ipos_r <= XW'(DEPTH));
    ipos_step   = ipos_r + (ipos_r & XW'(~ipos_r + XW'(1)));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fos_pkg::ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = fos_pkg::ST_IDLE;
        end
      end
      fos_pkg::ST_IDLE: begin
        if (start_i) begin
          if (op_i == fos_pkg::OP_INSERT) begin
            state_nxt = (ins_bad_dom || ins_full) ? fos_pkg::ST_FIN : fos_pkg::ST_INS;
          end else begin
            state_nxt = q_bad ? fos_pkg::ST_FIN : fos_pkg::ST_QRY;
          end
        end
      end
      fos_pkg::ST_INS: begin
        if (!ipos_in) begin
          state_nxt = fos_pkg::ST_FIN;
        end
      end
      fos_pkg::ST_QRY: begin
        if (last_r) begin
          state_nxt = fos_pkg::ST_FIN;
        end
      end
      fos_pkg::ST_FIN: begin
        if (out_free_i) begin
          state_nxt = fos_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fos_pkg::ST_CLEAR;
      end
    endcase
  end

  // Datapath and memory port control.
  always_comb begin
    clr_nxt    = clr_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    below_nxt  = below_r;
    k_nxt      = k_r;
    bit_nxt    = bit_r;
    last_nxt   = last_r;
    pend_nxt   = pend_r;
    cand_nxt   = cand_r;
    ipos_nxt   = ipos_r;
    wpend_nxt  = wpend_r;
    waddr_nxt  = waddr_r;
    status_nxt = status_r;
    kth_nxt    = kth_r;
    idle_o     = 1'b0;
    done_o     = 1'b0;
    rd_en_o    = 1'b0;
    rd_addr_o  = '0;
    wr_en_o    = 1'b0;
    wr_addr_o  = '0;
    wr_data_o  = '0;
    unique case (state_r)
      fos_pkg::ST_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = clr_r;
        clr_nxt   = AW'(clr_r + AW'(1));
      end
      fos_pkg::ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          kth_nxt = '0;
          if (op_i == fos_pkg::OP_INSERT) begin
            wpend_nxt = 1'b0;
            ipos_nxt  = XW'(value_i) + XW'(1);
            if (ins_bad_dom) begin
              status_nxt = fos_pkg::STAT_DOMAIN;
            end else if (ins_full) begin
              status_nxt = fos_pkg::STAT_FULL;
            end else begin
              status_nxt = fos_pkg::STAT_OK;
              cnt_nxt    = cnt_r + CW'(1);
            end
          end else begin
            k_nxt      = k_ext;
            pos_nxt    = '0;
            below_nxt  = '0;
            bit_nxt    = BW'(LOG_DEPTH);
            last_nxt   = 1'b0;
            pend_nxt   = 1'b0;
            status_nxt = q_bad ? fos_pkg::STAT_RANK : fos_pkg::STAT_OK;
          end
        end
      end
      fos_pkg::ST_INS: begin
        // Write back the entry read last cycle while reading the next one.
        if (wpend_r) begin
          wr_en_o   = 1'b1;
          wr_addr_o = waddr_r;
          wr_data_o = rd_data_i + CW'(1);
        end
        if (ipos_in) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(ipos_r - XW'(1));
          waddr_nxt = AW'(ipos_r - XW'(1));
          wpend_nxt = 1'b1;
          ipos_nxt  = ipos_step;
        end else begin
          wpend_nxt = 1'b0;
        end
      end
      fos_pkg::ST_QRY: begin
        pos_nxt   = pos_now;
        below_nxt = below_now;
        if (last_r) begin
          pend_nxt = 1'b0;
          if (pos_now >= dom_eff) begin
            status_nxt = fos_pkg::STAT_RANK;
          end else begin
            kth_nxt = fos_pkg::VALUE_W'(pos_now);
          end
        end else begin
          if (cand_ok) begin
            rd_en_o   = 1'b1;
            rd_addr_o = AW'(cand - XW'(1));
            pend_nxt  = 1'b1;
            cand_nxt  = cand;
          end else begin
            pend_nxt = 1'b0;
          end
          if (bit_r == '0) begin
            last_nxt = 1'b1;
          end else begin
            bit_nxt = bit_r - BW'(1);
          end
        end
      end
      fos_pkg::ST_FIN: begin
        done_o = out_free_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fos_pkg::ST_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      wpend_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      wpend_r <= wpend_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    below_r  <= below_nxt;
    k_r      <= k_nxt;
    bit_r    <= bit_nxt;
    cand_r   <= cand_nxt;
    ipos_r   <= ipos_nxt;
    waddr_r  <= waddr_nxt;
    status_r <= status_nxt;
    kth_r    <= kth_nxt;
  end

  assign result_o = '{status:      status_r,
                      kth_value:   kth_r,
                      total_count: fos_pkg::TOTAL_W'(cnt_r)};

  // The read-modify-write overlap never touches one entry from both ports.
  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en_o && rd_en_o) |-> (wr_addr_o != rd_addr_o))
    else $error("read and write of the same tree entry in one cycle");

  // The element count only ever steps up by one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |-> (cnt_r == CW'($past(cnt_r) + 1'b1)))
    else $error("element count changed by other than one");

  // Tree writes happen only while clearing or inserting.
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en_o |-> ((state_r == fos_pkg::ST_CLEAR) || (state_r == fos_pkg::ST_INS)))
    else $error("tree write outside clear or insert");

  // No insert write-back is left behind when a new item can be taken.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fos_pkg::ST_IDLE) |-> !wpend_r)
    else $error("pending tree write while idle");

endmodule

// ===== sv/fenwick_order_statistic_core.sv =====
// ----------------------------------------------------------------------------
// fenwick_order_statistic_core
// Binary indexed tree of counts with insert and k-th smallest query.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Beat contents
//  in_      input      in_valid / in_stall    operation, value, rank
//  out_     output     out_valid / out_stall  status, kth_value, total_count
//  cfg_     APB slave  psel/penable/pready    domain_size at byte address 0
//
// After reset the tree RAM is swept to zero, one entry per cycle, covering all
// DEPTH entries (1024 by default); in_stall stays high during the sweep, while
// register writes are accepted.
// An insert reads and writes back each of the n tree entries on its update
// path (at most LOG_DEPTH + 1); a query walks the bits of the position from
// bit LOG_DEPTH down to bit 0. Rejected beats go straight to the finish state.
// Both walks use the single RAM read port: the update path pipelines
// one read and one write-back per cycle, and the search issues at most one
// read per bit of the position.
// One item is worked on at a time. A finished result sits in the output
// register, so the next beat may be accepted while out_stall holds the
// previous result; the engine only waits when a second result is ready.
// ----------------------------------------------------------------------------
module fenwick_order_statistic_core #(
  parameter int unsigned DEPTH       = fos_pkg::DEPTH_DEF,
  parameter int unsigned LOG_DEPTH   = fos_pkg::LOG_DEPTH_DEF,
  parameter int unsigned COUNT_WIDTH = fos_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input beats.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [fos_pkg::VALUE_W-1:0]     in_value,
  input  logic [fos_pkg::RANK_W-1:0]      in_rank,
  // Result beats.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [fos_pkg::VALUE_W-1:0]     out_kth_value,
  output logic [fos_pkg::TOTAL_W-1:0]     out_total_count,
  // Register port.
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fos_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [fos_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [fos_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [fos_pkg::DOMAIN_W-1:0] domain_size;
  logic                         eng_idle;
  logic                         eng_done;
  fos_pkg::result_t             eng_result;
  logic                         in_accept;
  logic                         out_free;

  logic                         mem_rd_en;
  logic [AW-1:0]                mem_rd_addr;
  logic [COUNT_WIDTH-1:0]       mem_rd_data;
  logic                         mem_wr_en;
  logic [AW-1:0]                mem_wr_addr;
  logic [COUNT_WIDTH-1:0]       mem_wr_data;

  logic                         out_valid_r, out_valid_nxt;
  fos_pkg::result_t             out_result_r, out_result_nxt;

  // A beat is taken only while the engine sits idle; stall never looks at
  // in_valid.
  assign in_stall  = !eng_idle;
  assign in_accept = in_valid && !in_stall;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;

  fos_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .domain_size (domain_size)
  );

  fos_tree_mem #(
    .DEPTH (DEPTH),
    .WIDTH (COUNT_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  fos_engine #(
    .DEPTH       (DEPTH),
    .LOG_DEPTH   (LOG_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .domain_i   (domain_size),
    .start_i    (in_accept),
    .op_i       (in_operation),
    .value_i    (in_value),
    .rank_i     (in_rank),
    .out_free_i (out_free),
    .idle_o     (eng_idle),
    .done_o     (eng_done),
    .result_o   (eng_result),
    .rd_en_o    (mem_rd_en),
    .rd_addr_o  (mem_rd_addr),
    .rd_data_i  (mem_rd_data),
    .wr_en_o    (mem_wr_en),
    .wr_addr_o  (mem_wr_addr),
    .wr_data_o  (mem_wr_data)
  );

  // Result register: loaded when the engine finishes, cleared once the
  // beat is taken downstream.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    if (eng_done) begin
      out_valid_nxt  = 1'b1;
      out_result_nxt = eng_result;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_result_r.status;
  assign out_kth_value   = out_result_r.kth_value;
  assign out_total_count = out_result_r.total_count;

endmodule
